[sv/assert_macros.svh]
// Assertion helpers for the RTL, included by mptc_back.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

[sv/mptc_pkg.sv]
package mptc_pkg;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 1'b1;

  // Register reset values.
  localparam logic [31:0] MIN_SPACING_RESET     = 32'd655360;
  localparam logic [31:0] LEVEL_THRESHOLD_RESET = 32'd0;

  // One classified input request.
  typedef struct packed {
    logic [31:0] sample;
    logic [31:0] time_stamp;
    logic [5:0]  channel;
    logic        frame_end;
    logic        in_range;
  } item_t;

  // One result request.
  typedef struct packed {
    logic        channel_peak;
    logic [2:0]  channel_slot;
    logic [31:0] peak_time;
    logic        mean_peak;
    logic [2:0]  mean_slot;
    logic        all_full;
  } result_t;

  // Configuration write.
  typedef struct packed {
    logic                 write;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } cfg_t;

endpackage

[sv/multichannel_peak_time_capture.sv]
// Multichannel peak time capture. Frames of samples arrive one channel per
// request, channels 0..CHANNELS-1 closed by frame_end with the frame time
// stamp; each request gives exactly one result. A channel, and the frame sum
// as an extra channel, records the previous frame's time as a peak when its
// previous sample is a strict local maximum above level_threshold (the sum
// uses level_threshold*CHANNELS), up to PEAKS peaks, each after the first
// more than min_spacing after the last. The block sustains one request per
// clock while the result queue has room: per-channel history lives in a
// memory with one read-modify-write per request, read as the request leaves
// the input queue and written in the next cycle, with a bypass for
// back-to-back requests on the same channel. A request passes the input
// queue, the execute stage registers and the result queue. The user must
// write configuration only while the block is idle, which is not enforced.
module multichannel_peak_time_capture #(
  parameter int CHANNELS = 64,
  parameter int PEAKS    = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [31:0]           sample,
  input  logic [31:0]                  time_stamp,
  input  logic [5:0]                   channel,
  input  logic                         frame_end,
  output logic                         empty,
  input  logic                         pop,
  output logic                         channel_peak,
  output logic [2:0]                   channel_slot,
  output logic [31:0]                  peak_time,
  output logic                         mean_peak,
  output logic [2:0]                   mean_slot,
  output logic                         all_full,
  input  logic                         cfg_write,
  input  logic [mptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                  cfg_data
);

  import mptc_pkg::*;

  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 4;

  cfg_t                          cfg;
  item_t                         in_head;
  logic                          in_empty;
  logic                          in_pop;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  logic                          res_write;
  result_t                       res;
  logic [$bits(result_t)-1:0]    out_bits;
  result_t                       out_res;

  assign cfg.write = cfg_write;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Front: classification and input queue.
  mptc_front #(
    .CHANNELS (CHANNELS),
    .DEPTH    (IN_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .sample     (sample),
    .time_stamp (time_stamp),
    .channel    (channel),
    .frame_end  (frame_end),
    .pop        (in_pop),
    .head       (in_head),
    .empty      (in_empty)
  );

  // Back: history memory, sum track and peak recording.
  mptc_back #(
    .CHANNELS  (CHANNELS),
    .PEAKS     (PEAKS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_head   (in_head),
    .in_empty  (in_empty),
    .in_pop    (in_pop),
    .out_count (out_count),
    .res_write (res_write),
    .res       (res)
  );

  // Result queue toward the consumer.
  mptc_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_write),
    .wr_data (res),
    .full    (),
    .rd_en   (pop),
    .rd_data (out_bits),
    .empty   (empty),
    .count   (out_count)
  );

  assign out_res      = result_t'(out_bits);
  assign channel_peak = out_res.channel_peak;
  assign channel_slot = out_res.channel_slot;
  assign peak_time    = out_res.peak_time;
  assign mean_peak    = out_res.mean_peak;
  assign mean_slot    = out_res.mean_slot;
  assign all_full     = out_res.all_full;

endmodule

[sv/mptc_queue.sv]
module mptc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  output logic                       full,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [0:DEPTH-1];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[head];

  // Storage is written at the tail and has no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[tail] <= wr_data;
    end
  end

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + PTR_W'(1);
      end
      if (do_rd) begin
        head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[sv/mptc_front.sv]
module mptc_front #(
  parameter int CHANNELS = 64,
  parameter int DEPTH    = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  sample,
  input  logic [31:0]         time_stamp,
  input  logic [5:0]          channel,
  input  logic                frame_end,
  input  logic                pop,
  output mptc_pkg::item_t     head,
  output logic                empty
);

  import mptc_pkg::*;

  item_t                  item;
  logic [$bits(item_t)-1:0] head_bits;

  // Classify the request: a channel at or beyond CHANNELS is flagged out of range.
  always_comb begin
    item.sample     = sample;
    item.time_stamp = time_stamp;
    item.channel    = channel;
    item.frame_end  = frame_end;
    item.in_range   = (32'(channel) < 32'(CHANNELS));
  end

  // Short queue decoupling the source from the update pipeline.
  mptc_queue #(
    .WIDTH ($bits(item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (item),
    .full    (full),
    .rd_en   (pop),
    .rd_data (head_bits),
    .empty   (empty),
    .count   ()
  );

  assign head = item_t'(head_bits);

endmodule

[sv/mptc_back.sv]
`include "assert_macros.svh"

module mptc_back #(
  parameter int CHANNELS  = 64,
  parameter int PEAKS     = 5,
  parameter int OUT_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mptc_pkg::cfg_t                 cfg,
  input  mptc_pkg::item_t                in_head,
  input  logic                           in_empty,
  output logic                           in_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_write,
  output mptc_pkg::result_t              res
);

  import mptc_pkg::*;

  // Only channel numbers that fit the 6-bit field can ever be stored.
  localparam int TRACKS = (CHANNELS < 64) ? CHANNELS : 64;
  localparam int IDX_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int CNT_W  = $clog2(PEAKS + 1);
  localparam int SUM_W  = 32 + (($clog2(CHANNELS) > 6) ? $clog2(CHANNELS) : 6);
  localparam int FULL_W = $clog2(TRACKS + 2);
  localparam int OC_W   = $clog2(OUT_DEPTH + 1);
  localparam logic signed [SUM_W-1:0] CH_SCALE = SUM_W'(CHANNELS);

  typedef struct packed {
    logic [31:0]      prev1;
    logic [31:0]      prev2;
    logic [CNT_W-1:0] count;
    logic [31:0]      last;
  } entry_t;

  // Configuration registers.
  logic [31:0]              min_spacing;
  logic signed [31:0]       level_threshold;
  logic signed [SUM_W-1:0]  sum_level;

  // Per-channel history memory with valid bits standing for the zero reset.
  entry_t                   mem [0:TRACKS-1];
  logic [TRACKS-1:0]        valid;

  // Execute stage registers.
  logic                     e_valid;
  item_t                    e_item;
  entry_t                   rd_entry;
  logic                     e_rd_valid;
  logic                     e_fwd;
  entry_t                   fwd_entry;

  // Frame sum track and global state.
  logic signed [SUM_W-1:0]  frame_sum;
  logic signed [SUM_W-1:0]  s_prev1;
  logic signed [SUM_W-1:0]  s_prev2;
  logic [CNT_W-1:0]         s_count;
  logic [31:0]              s_last;
  logic [31:0]              prev_time;
  logic                     frame_active;
  logic [FULL_W-1:0]        full_count;

  // Execute stage logic.
  logic [IDX_W-1:0]         pop_idx;
  logic [IDX_W-1:0]         e_idx;
  entry_t                   entry;
  entry_t                   wr_entry;
  logic                     wr;
  logic signed [31:0]       now;
  logic [32:0]              ch_gap;
  logic                     ch_cand;
  logic                     ch_rec;
  logic                     ch_full;
  logic signed [SUM_W-1:0]  sum_now;
  logic [32:0]              s_gap;
  logic                     mean_cand;
  logic                     mean_rec;
  logic                     mean_full;
  logic [FULL_W-1:0]        full_next;
  logic                     all_full;

  // Configuration writes; the sum level is scaled once here.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_spacing     <= MIN_SPACING_RESET;
      level_threshold <= $signed(LEVEL_THRESHOLD_RESET);
      sum_level       <= SUM_W'($signed(LEVEL_THRESHOLD_RESET)) * CH_SCALE;
    end else if (cfg.write) begin
      unique case (cfg.index)
        REG_MIN_SPACING: begin
          min_spacing <= cfg.data;
        end
        REG_LEVEL_THRESHOLD: begin
          level_threshold <= $signed(cfg.data);
          sum_level       <= SUM_W'($signed(cfg.data)) * CH_SCALE;
        end
      endcase
    end
  end

  // Pop only when the result queue has room for everything in flight.
  assign in_pop  = !in_empty &&
                   (({1'b0, out_count} + (OC_W + 1)'(e_valid)) < (OC_W + 1)'(OUT_DEPTH));
  assign pop_idx = IDX_W'(in_head.channel);
  assign e_idx   = IDX_W'(e_item.channel);

  // Channel track: strict local maximum above the level, spaced from the last peak.
  always_comb begin
    if (e_fwd) begin
      entry = fwd_entry;
    end else if (e_rd_valid) begin
      entry = rd_entry;
    end else begin
      entry = '0;
    end
    now     = $signed(e_item.sample);
    ch_gap  = {1'b0, prev_time} - {1'b0, entry.last};
    ch_cand = ($signed(entry.prev1) > level_threshold) &&
              ($signed(entry.prev1) > $signed(entry.prev2)) &&
              ($signed(entry.prev1) > now) &&
              (entry.count < CNT_W'(PEAKS));
    ch_rec  = e_valid && frame_active && e_item.in_range && ch_cand &&
              ((entry.count == '0) || (!ch_gap[32] && (ch_gap[31:0] > min_spacing)));
    ch_full = ch_rec && (entry.count == CNT_W'(PEAKS - 1));
    wr      = e_valid && frame_active && e_item.in_range;

    wr_entry.prev2 = entry.prev1;
    wr_entry.prev1 = e_item.sample;
    wr_entry.count = ch_rec ? entry.count + CNT_W'(1) : entry.count;
    wr_entry.last  = ch_rec ? prev_time : entry.last;
  end

  // Sum track, closed at the end of each frame.
  always_comb begin
    sum_now   = frame_sum + (e_item.in_range ? SUM_W'(now) : '0);
    s_gap     = {1'b0, prev_time} - {1'b0, s_last};
    mean_cand = (s_prev1 > sum_level) && (s_prev1 > s_prev2) && (s_prev1 > sum_now) &&
                (s_count < CNT_W'(PEAKS));
    mean_rec  = e_valid && frame_active && e_item.frame_end && mean_cand &&
                ((s_count == '0) || (!s_gap[32] && (s_gap[31:0] > min_spacing)));
    mean_full = mean_rec && (s_count == CNT_W'(PEAKS - 1));
    full_next = full_count + FULL_W'(ch_full) + FULL_W'(mean_full);
    all_full  = (32'(full_next) >= 32'(CHANNELS + 1));
  end

  // Result request.
  always_comb begin
    res_write        = e_valid;
    res.channel_peak = ch_rec;
    res.channel_slot = ch_rec ? 3'(entry.count) : 3'd0;
    res.peak_time    = (ch_rec || mean_rec) ? prev_time : 32'd0;
    res.mean_peak    = mean_rec;
    res.mean_slot    = mean_rec ? 3'(s_count) : 3'd0;
    res.all_full     = all_full;
  end

  // Memory read at pop with a bypass of the write in the same cycle.
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[e_idx] <= wr_entry;
    end
    if (in_pop) begin
      e_item     <= in_head;
      rd_entry   <= mem[pop_idx];
      e_rd_valid <= valid[pop_idx];
      e_fwd      <= wr && (e_idx == pop_idx);
      fwd_entry  <= wr_entry;
    end
  end

  // Control state of the execute stage and the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      e_valid      <= 1'b0;
      frame_sum    <= '0;
      s_prev1      <= '0;
      s_prev2      <= '0;
      s_count      <= '0;
      prev_time    <= '0;
      frame_active <= 1'b1;
      full_count   <= '0;
    end else begin
      e_valid <= in_pop;
      if (wr) begin
        valid[e_idx] <= 1'b1;
      end
      if (e_valid && frame_active) begin
        full_count <= full_next;
        if (e_item.frame_end) begin
          s_prev2      <= s_prev1;
          s_prev1      <= sum_now;
          frame_sum    <= '0;
          prev_time    <= e_item.time_stamp;
          frame_active <= !all_full;
          if (mean_rec) begin
            s_count <= s_count + CNT_W'(1);
          end
        end else begin
          frame_sum <= sum_now;
        end
      end
    end
  end

  // The last peak time of the sum track needs no reset.
  always_ff @(posedge clk) begin
    if (mean_rec) begin
      s_last <= prev_time;
    end
  end

  `ASSERT_IMP(a_mean_on_frame_end, clk, rst, mean_rec, e_item.frame_end, "mean peak off frame end")
  `ASSERT_IMP(a_result_room, clk, rst, e_valid, out_count < OC_W'(OUT_DEPTH), "result queue overrun")
  `ASSERT_NXT(a_gate_sticky, clk, rst, !frame_active, !frame_active, "frame gate reopened")
  `ASSERT_IMP(a_full_bound, clk, rst, 1'b1, 32'(full_count) <= 32'(TRACKS + 1), "full count too large")

endmodule

[tb/sv/testbench.sv]
module testbench;
  import mptc_pkg::*;

  localparam int NUM_CHANNELS  = 64;
  localparam int MAX_PEAKS     = 5;
  localparam int SUM_TRACK     = NUM_CHANNELS;
  localparam int NUM_TRACKS    = NUM_CHANNELS + 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int TIMEOUT       = 2_000_000;

  typedef enum int {WAVE_FRAME, NOISE_FRAME, BROKEN_FRAME} frame_kind_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 push = 1'b0;
  logic                 full;
  logic [31:0]          sample = '0;
  logic [31:0]          time_stamp = '0;
  logic [5:0]           channel = '0;
  logic                 frame_end = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic                 channel_peak;
  logic [2:0]           channel_slot;
  logic [31:0]          peak_time;
  logic                 mean_peak;
  logic [2:0]           mean_slot;
  logic                 all_full;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  multichannel_peak_time_capture dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .sample(sample), .time_stamp(time_stamp), .channel(channel), .frame_end(frame_end),
    .empty(empty), .pop(pop),
    .channel_peak(channel_peak), .channel_slot(channel_slot), .peak_time(peak_time),
    .mean_peak(mean_peak), .mean_slot(mean_slot), .all_full(all_full),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Peak detector state: one track per channel plus one for the frame sum.
  logic signed [37:0] hist1 [NUM_TRACKS];
  logic signed [37:0] hist2 [NUM_TRACKS];
  logic [31:0]        stamps [NUM_TRACKS][MAX_PEAKS];
  logic [2:0]         count [NUM_TRACKS];
  logic signed [37:0] sum_acc;
  logic [31:0]        last_frame_time;
  bit                 gate_open;
  int                 full_tracks;
  logic [31:0]        min_gap;
  logic signed [31:0] level;

  result_t expected_peaks [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold = 0;
  int mismatches = 0;
  int items_sent = 0;
  int frames_sent = 0;
  int channel_peaks = 0;
  int sum_peaks = 0;
  logic [31:0] frame_clock = '0;

  function automatic void reset_model();
    for (int k = 0; k < NUM_TRACKS; k++) begin
      hist1[k] = '0;
      hist2[k] = '0;
      count[k] = '0;
      for (int p = 0; p < MAX_PEAKS; p++) stamps[k][p] = '0;
    end
    sum_acc = '0;
    last_frame_time = '0;
    gate_open = 1'b1;
    full_tracks = 0;
    min_gap = MIN_SPACING_RESET;
    level = LEVEL_THRESHOLD_RESET;
  endfunction

  // Shift one track's history and decide whether it records a peak.
  function automatic bit update_track(input int k, input logic signed [37:0] now,
                                      input logic signed [37:0] floor_lvl,
                                      output logic [2:0] slot);
    logic signed [37:0] older;
    logic signed [37:0] past;
    logic [2:0]         n;
    logic signed [33:0] gap;
    bit                 hit;
    older = hist2[k];
    past = hist1[k];
    n = count[k];
    hit = 1'b0;
    slot = '0;
    hist2[k] = past;
    hist1[k] = now;
    if (past > floor_lvl && past > older && past > now && n < MAX_PEAKS) begin
      if (n == 0) begin
        hit = 1'b1;
      end else begin
        // The gap is a true signed difference, so time going backwards never passes.
        gap = $signed({2'b00, last_frame_time}) - $signed({2'b00, stamps[k][n - 1]});
        hit = gap > $signed({2'b00, min_gap});
      end
    end
    if (hit) begin
      stamps[k][n] = last_frame_time;
      count[k] = n + 3'd1;
      if (n + 1 == MAX_PEAKS) full_tracks++;
      slot = n;
    end
    return hit;
  endfunction

  // Expected result of one accepted request; advances the detector state.
  function automatic result_t detect_peaks(input logic signed [31:0] s, input logic [31:0] ts,
                                           input logic [5:0] ch, input logic fe);
    result_t            r;
    logic [2:0]         slot;
    logic [31:0]        then_time;
    logic signed [37:0] sum_floor;
    r = '0;
    then_time = last_frame_time;
    sum_floor = level;
    sum_floor = sum_floor * NUM_CHANNELS;
    if (gate_open) begin
      // Every 6-bit channel number is below NUM_CHANNELS, so each sample counts.
      sum_acc = sum_acc + s;
      r.channel_peak = update_track(ch, s, level, slot);
      r.channel_slot = r.channel_peak ? slot : 3'd0;
      if (fe) begin
        r.mean_peak = update_track(SUM_TRACK, sum_acc, sum_floor, slot);
        r.mean_slot = r.mean_peak ? slot : 3'd0;
        sum_acc = '0;
        last_frame_time = ts;
        gate_open = full_tracks < NUM_TRACKS;
      end
    end
    if (r.channel_peak || r.mean_peak) r.peak_time = then_time;
    r.all_full = full_tracks >= NUM_TRACKS;
    channel_peaks += r.channel_peak;
    sum_peaks += r.mean_peak;
    return r;
  endfunction

  function automatic logic [31:0] wave_value(input bit high);
    return high ? (($urandom & 32'h3FFF_FFFF) | 32'h4000_0000) : ($urandom | 32'h8000_0000);
  endfunction

  function automatic frame_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    return (r < 60) ? WAVE_FRAME : ((r < 80) ? NOISE_FRAME : BROKEN_FRAME);
  endfunction

  // Offer one request, wait until it is taken, then queue its expected result.
  task automatic send_item(input logic [31:0] s, input logic [31:0] ts,
                           input logic [5:0] ch, input logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    sample <= s;
    time_stamp <= ts;
    channel <= ch;
    frame_end <= fe;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_peaks.push_back(detect_peaks(s, ts, ch, fe));
    items_sent++;
  endtask

  // One frame of channels 0..63; broken frames skip channels, add strays and close early.
  task automatic send_frame(input frame_kind_t kind, input bit high,
                            input int unsigned step_max, input int back_pct);
    int unsigned pick;
    if ($urandom_range(99) < back_pct) begin
      frame_clock = frame_clock - $urandom_range(step_max);
    end else begin
      frame_clock = frame_clock + $urandom_range(step_max, 1);
    end
    for (int ch = 0; ch < NUM_CHANNELS - 1; ch++) begin
      pick = $urandom_range(99);
      case (kind)
        NOISE_FRAME: begin
          send_item($urandom, $urandom, 6'(ch), 1'b0);
        end
        BROKEN_FRAME: begin
          if (pick >= 22) begin
            send_item(wave_value(high), $urandom, 6'(ch), 1'b0);
          end else if (pick >= 15) begin
            send_item($urandom, frame_clock, 6'($urandom_range(NUM_CHANNELS - 1)), pick < 18);
          end
        end
        default: begin
          send_item(wave_value(high ^ (pick >= 95)), $urandom, 6'(ch), 1'b0);
        end
      endcase
    end
    send_item(kind == NOISE_FRAME ? $urandom : wave_value(high), frame_clock,
              6'(NUM_CHANNELS - 1), 1'b1);
    frames_sent++;
  endtask

  // Stop offering, wait for every expected result, then let the pipeline empty.
  task automatic settle();
    push <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers while the block is idle.
  task automatic set_config(input logic [31:0] gap, input logic [31:0] lvl);
    cfg_write <= 1'b1;
    cfg_index <= REG_MIN_SPACING;
    cfg_data <= gap;
    @(posedge clk);
    cfg_index <= REG_LEVEL_THRESHOLD;
    cfg_data <= lvl;
    @(posedge clk);
    cfg_write <= 1'b0;
    min_gap = gap;
    level = lvl;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_peaks.size() == 0) begin
      $error("result request arrived with no expected result waiting");
      mismatches++;
    end else begin
      want = expected_peaks.pop_front();
      check_field("channel_peak", want.channel_peak, channel_peak);
      check_field("channel_slot", want.channel_slot, channel_slot);
      check_field("peak_time", want.peak_time, peak_time);
      check_field("mean_peak", want.mean_peak, mean_peak);
      check_field("mean_slot", want.mean_slot, mean_slot);
      check_field("all_full", want.all_full, all_full);
    end
  endtask

  // Result side: check each taken result, then decide whether to pop next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (pop && !empty) check_result();
      if (rst) begin
        pop <= 1'b0;
      end else if (recv_hold > 0) begin
        pop <= 1'b0;
        recv_hold--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Reset values, channel 0 frames of one request each: extremes, spacing edge,
  // time going backwards, plateaus and peaks below the level.
  task automatic test_directed_edges();
    send_idle_pct = 17;
    recv_idle_pct = 57;
    send_item(32'h7FFF_FFFF, 32'h0064_0000, 6'd0, 1'b1);
    send_item(32'h8000_0000, 32'h0065_0000, 6'd0, 1'b1);
    send_item(32'h4000_0000, 32'h006E_0000, 6'd0, 1'b1);
    // Gap equal to min_spacing is rejected.
    send_item(32'h0000_0000, 32'h006F_0000, 6'd0, 1'b1);
    send_item(32'h5000_0000, 32'h0070_0000, 6'd0, 1'b1);
    send_item(32'hFFFF_FFFF, 32'h0071_0000, 6'd0, 1'b1);
    // Frame time goes backwards before the next local maximum.
    send_item(32'h6000_0000, 32'h0005_0000, 6'd0, 1'b1);
    send_item(32'h0000_0001, 32'h0006_0000, 6'd0, 1'b1);
    // A plateau is no strict maximum.
    send_item(32'h1000_0000, 32'h0200_0000, 6'd0, 1'b1);
    send_item(32'h1000_0000, 32'h0201_0000, 6'd0, 1'b1);
    send_item(32'h0000_0000, 32'h0202_0000, 6'd0, 1'b1);
    // A maximum that stays below the level.
    send_item(32'hFFFF_FFF0, 32'h0203_0000, 6'd0, 1'b1);
    send_item(32'hFFFF_FFFF, 32'h0204_0000, 6'd0, 1'b1);
    send_item(32'hFFFF_FF00, 32'h0205_0000, 6'd0, 1'b1);
    // A frame of several channels, closed with the largest and smallest time.
    send_item(32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b0);
    send_item(32'h8000_0000, 32'h0000_0000, 6'd1, 1'b0);
    send_item(32'h0000_0000, 32'hFFFF_FFFF, 6'd0, 1'b1);
    send_item(32'h2000_0000, 32'h0000_0000, 6'd0, 1'b1);
    send_item(32'h8000_0000, 32'h0300_0000, 6'd63, 1'b1);
    settle();
  endtask

  // Largest spacing: each track can record its first peak only.
  task automatic test_first_peak_only();
    set_config(32'hFFFF_FFFF, 32'h0000_0000);
    frame_clock = 32'h0400_0000;
    for (int f = 0; f < 5; f++) send_frame(WAVE_FRAME, f[0], 32'h0010_0000, 0);
    settle();
  endtask

  // Highest level: no sample and no sum can exceed it.
  task automatic test_level_ceiling();
    send_idle_pct = 57;
    recv_idle_pct = 17;
    set_config($urandom, 32'h7FFF_FFFF);
    for (int f = 0; f < 5; f++) send_frame(pick_kind(), f[0], 32'h0010_0000, 0);
    settle();
  endtask

  // Lowest level, short spacing, times that sometimes step back, and a long
  // result stall that fills the block.
  task automatic test_spacing_under_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(32'h0003_0000, 32'h8000_0000);
    recv_hold = HOLD_CYCLES;
    for (int f = 0; f < 6; f++) send_frame(pick_kind(), f[0], 32'h0006_0000, 20);
    settle();
  endtask

  // Zero spacing fills every track; the frames after that are ignored.
  task automatic test_fill_and_gating();
    set_config(32'h0000_0000, $urandom | 32'h8000_0000);
    frame_clock = 32'hF000_0000;
    for (int f = 0; f < 16 && gate_open; f++) send_frame(WAVE_FRAME, f[0], 32'h0008_0000, 0);
    send_frame(WAVE_FRAME, 1'b1, 32'h0008_0000, 0);
    settle();
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_first_peak_only();
    test_level_ceiling();
    test_spacing_under_stall();
    test_fill_and_gating();
    $display("Sent %0d requests in %0d frames over reset values and four register settings.",
             items_sent, frames_sent);
    $display("Recorded %0d channel peaks and %0d sum peaks; all tracks full: %0d.",
             channel_peaks, sum_peaks, !gate_open);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a run that hangs on a handshake.
  initial begin
    #(TIMEOUT);
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/mptc_pkg.sv
sv/mptc_queue.sv
sv/mptc_front.sv
sv/mptc_back.sv
sv/multichannel_peak_time_capture.sv
tb/sv/testbench.sv
